/* sv/fsc_pkg.sv */
// Shared types and constants for the format specifier checker.
// Holds the scan phase encoding, character codes and the character class bundle.
// No dependencies.
package fsc_pkg;

    // Scan phase, one-hot
    typedef enum logic [9:0] {
        PH_EXPECT_PCT = 10'b00_0000_0001,
        PH_AFTER_PCT  = 10'b00_0000_0010,
        PH_AFTER_FLAG = 10'b00_0000_0100,
        PH_WIDTH      = 10'b00_0000_1000,
        PH_PREC       = 10'b00_0001_0000,
        PH_AFTER_LEN  = 10'b00_0010_0000,
        PH_CONV       = 10'b00_0100_0000,
        PH_TERM       = 10'b00_1000_0000,
        PH_DONE_OK    = 10'b01_0000_0000,
        PH_DONE_BAD   = 10'b10_0000_0000
    } t_phase;

    // Verdict codes
    localparam logic [1:0] VERDICT_SCAN    = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    // Value kind codes
    localparam logic [2:0] KIND_FLOAT    = 3'd0;
    localparam logic [2:0] KIND_SIGNED   = 3'd1;
    localparam logic [2:0] KIND_UNSIGNED = 3'd2;
    localparam logic [2:0] KIND_STRING   = 3'd3;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_S       = 8'h73;

    // Classification of one character against the current value kind
    typedef struct packed {
        logic is_pct;
        logic is_flag;
        logic is_digit;
        logic is_star;
        logic is_dot;
        logic is_len;
        logic is_hl;
        logic is_conv_ok;
        logic is_nul;
    } t_char_class;

endpackage

/* sv/fsc_class.sv */
// Character classifier for the format specifier checker.
// Compares one character against the syntax classes and the allowed conversions.
// Depends on fsc_pkg.
module fsc_class (
    input  logic [fsc_pkg::CHAR_W-1:0] i_char,
    input  logic [fsc_pkg::KIND_W-1:0] i_kind,
    output fsc_pkg::t_char_class       o_class
);

    // Conversion letters allowed by each value kind
    function automatic logic kind_allows(input logic [fsc_pkg::KIND_W-1:0] kind,
                                         input logic [fsc_pkg::CHAR_W-1:0] c);
        logic ok;
        begin
            case (kind)
                fsc_pkg::KIND_FLOAT: begin
                    ok = (c == 8'h66) || (c == 8'h46) || (c == 8'h65) || (c == 8'h45) ||
                         (c == 8'h67) || (c == 8'h47) || (c == 8'h61) || (c == 8'h41);
                end
                fsc_pkg::KIND_SIGNED: begin
                    ok = (c == 8'h64) || (c == 8'h69) || (c == 8'h63);
                end
                fsc_pkg::KIND_UNSIGNED: begin
                    ok = (c == 8'h75) || (c == 8'h6F) || (c == 8'h78) || (c == 8'h58);
                end
                fsc_pkg::KIND_STRING: begin
                    ok = (c == fsc_pkg::CH_S);
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
            return ok;
        end
    endfunction

    // Classify the character
    always_comb begin
        o_class.is_pct     = (i_char == fsc_pkg::CH_PERCENT);
        o_class.is_flag    = (i_char == fsc_pkg::CH_PLUS) || (i_char == fsc_pkg::CH_MINUS) ||
                             (i_char == fsc_pkg::CH_SPACE) || (i_char == fsc_pkg::CH_HASH) ||
                             (i_char == fsc_pkg::CH_ZERO);
        o_class.is_digit   = (i_char >= fsc_pkg::CH_ZERO) && (i_char <= fsc_pkg::CH_NINE);
        o_class.is_star    = (i_char == fsc_pkg::CH_STAR);
        o_class.is_dot     = (i_char == fsc_pkg::CH_DOT);
        o_class.is_hl      = (i_char == fsc_pkg::CH_H) || (i_char == fsc_pkg::CH_L);
        o_class.is_len     = o_class.is_hl || (i_char == fsc_pkg::CH_J) ||
                             (i_char == fsc_pkg::CH_Z) || (i_char == fsc_pkg::CH_T) ||
                             (i_char == fsc_pkg::CH_UP_L);
        o_class.is_conv_ok = kind_allows(i_kind, i_char);
        o_class.is_nul     = (i_char == fsc_pkg::CH_NUL);
    end

endmodule

/* sv/fsc_phase.sv */
// Scan phase machine and result register for the format specifier checker.
// Holds the phase and value kind, and registers verdict and finished per item.
// Depends on fsc_pkg and fsc_class.
module fsc_phase (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [fsc_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_start,
    input  logic [fsc_pkg::KIND_W-1:0] i_kind,
    output fsc_pkg::t_phase            o_phase,
    output logic [1:0]                 o_verdict,
    output logic                       o_finished
);

    fsc_pkg::t_phase             r_phase;
    fsc_pkg::t_phase             n_phase;
    fsc_pkg::t_phase             w_cur;
    logic [fsc_pkg::KIND_W-1:0]  r_kind;
    logic [fsc_pkg::KIND_W-1:0]  w_kind;
    fsc_pkg::t_char_class        w_class;
    logic [1:0]                  r_verdict;
    logic [1:0]                  n_verdict;
    logic                        r_finished;

    // A start marker restarts the scan and takes the new kind
    assign w_cur  = i_start ? fsc_pkg::PH_EXPECT_PCT : r_phase;
    assign w_kind = i_start ? i_kind : r_kind;

    fsc_class u_class (
        .i_char  (i_char),
        .i_kind  (w_kind),
        .o_class (w_class)
    );

    // Conversion letter or reject
    function automatic fsc_pkg::t_phase f_conv(input fsc_pkg::t_char_class cl);
        return cl.is_conv_ok ? fsc_pkg::PH_TERM : fsc_pkg::PH_DONE_BAD;
    endfunction

    // Precision digits, then length, then conversion
    function automatic fsc_pkg::t_phase f_prec(input fsc_pkg::t_char_class cl);
        fsc_pkg::t_phase p;
        begin
            if (cl.is_digit) begin
                p = fsc_pkg::PH_PREC;
            end else if (cl.is_star) begin
                p = fsc_pkg::PH_DONE_BAD;
            end else if (cl.is_len) begin
                p = fsc_pkg::PH_AFTER_LEN;
            end else begin
                p = f_conv(cl);
            end
            return p;
        end
    endfunction

    // Width digits, then dot, then fall to the precision rules
    function automatic fsc_pkg::t_phase f_width(input fsc_pkg::t_char_class cl);
        fsc_pkg::t_phase p;
        begin
            if (cl.is_digit) begin
                p = fsc_pkg::PH_WIDTH;
            end else if (cl.is_star) begin
                p = fsc_pkg::PH_DONE_BAD;
            end else if (cl.is_dot) begin
                p = fsc_pkg::PH_PREC;
            end else begin
                p = f_prec(cl);
            end
            return p;
        end
    endfunction

    // Next phase
    always_comb begin
        unique case (w_cur) inside
            fsc_pkg::PH_EXPECT_PCT: begin
                n_phase = w_class.is_pct ? fsc_pkg::PH_AFTER_PCT : fsc_pkg::PH_DONE_BAD;
            end
            fsc_pkg::PH_AFTER_PCT: begin
                n_phase = w_class.is_flag ? fsc_pkg::PH_AFTER_FLAG : f_width(w_class);
            end
            fsc_pkg::PH_AFTER_FLAG, fsc_pkg::PH_WIDTH: begin
                n_phase = f_width(w_class);
            end
            fsc_pkg::PH_PREC: begin
                n_phase = f_prec(w_class);
            end
            fsc_pkg::PH_AFTER_LEN: begin
                n_phase = w_class.is_hl ? fsc_pkg::PH_CONV : f_conv(w_class);
            end
            fsc_pkg::PH_CONV: begin
                n_phase = f_conv(w_class);
            end
            fsc_pkg::PH_TERM: begin
                n_phase = w_class.is_nul ? fsc_pkg::PH_DONE_OK : fsc_pkg::PH_DONE_BAD;
            end
            fsc_pkg::PH_DONE_OK: begin
                n_phase = fsc_pkg::PH_DONE_OK;
            end
            default: begin
                n_phase = fsc_pkg::PH_DONE_BAD;
            end
        endcase
    end

    // Verdict of the new phase
    always_comb begin
        if (n_phase == fsc_pkg::PH_DONE_OK) begin
            n_verdict = fsc_pkg::VERDICT_VALID;
        end else if (n_phase == fsc_pkg::PH_DONE_BAD) begin
            n_verdict = fsc_pkg::VERDICT_INVALID;
        end else begin
            n_verdict = fsc_pkg::VERDICT_SCAN;
        end
    end

    // Advance state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fsc_pkg::PH_EXPECT_PCT;
            r_kind  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_kind  <= w_kind;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_verdict  <= n_verdict;
            r_finished <= (n_verdict != fsc_pkg::VERDICT_SCAN);
        end
    end

    assign o_phase    = r_phase;
    assign o_verdict  = r_verdict;
    assign o_finished = r_finished;

endmodule

/* sv/format_specifier_checker.sv */
// Top level of the format specifier checker: input register, phase machine, handshakes.
// Depends on fsc_pkg and fsc_phase.
//
// Usage:
//   Input stream: one specifier character per item. i_s_tdata carries char_code,
//   i_s_tuser carries start_of_string (bit 0) and value_kind (bits 3:1). Mark the
//   first character of each specifier with start_of_string; value_kind is taken
//   only on that item. End each specifier with a zero byte.
//   Output stream: one item per input item, in order. o_m_tdata carries verdict
//   (bits 1:0: scanning, valid, invalid) and finished (bit 2), zero above.
//   Once finished is set, the verdict holds for the rest of the string.
// Timing:
//   The result is registered: an accepted input passes the input register, then
//   the result register, before it is offered on the output stream.
//   One item per cycle sustained while i_m_tready stays high; the phase register
//   updates in the same cycle the item moves into the result register.
// Reset and stalls:
//   Reset clears both stages and returns the scan to expect a percent sign with
//   the float kind. When the receiver holds i_m_tready low, the result holds, one
//   more item waits in the input register, and then i_s_tready drops.
module format_specifier_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic [3:0] i_s_tuser,   // [0] start_of_string, [3:1] value_kind
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] verdict, [2] finished, [7:3] zero
);

    logic                        r_in_valid;
    logic [fsc_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_start;
    logic [fsc_pkg::KIND_W-1:0]  r_in_kind;
    logic                        r_out_valid;
    logic                        w_adv;
    logic                        w_in_take;
    fsc_pkg::t_phase             w_phase;
    logic [1:0]                  w_verdict;
    logic                        w_finished;

    // Move an item to the result stage when the result slot is free or drains
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char  <= i_s_tdata;
            r_in_start <= i_s_tuser[0];
            r_in_kind  <= i_s_tuser[3:1];
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    fsc_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_char     (r_in_char),
        .i_start    (r_in_start),
        .i_kind     (r_in_kind),
        .o_phase    (w_phase),
        .o_verdict  (w_verdict),
        .o_finished (w_finished)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0_0000, w_finished, w_verdict};

    // Phase register stays one-hot
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_phase))
        else $error("scan phase not one-hot");

    // Finished flag agrees with the verdict
    a_finished_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (w_finished == (w_verdict != fsc_pkg::VERDICT_SCAN)))
        else $error("finished flag disagrees with verdict");

    // A waiting item stays in the input register until it moves on
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("input item lost while stalled");

    // No verdict code outside the three defined ones
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (w_verdict != 2'd3))
        else $error("undefined verdict code");

endmodule
